@@ rtl/k_smallest_distance_list_assert.svh @@
// ----------------------------------------------------------------------------
// k smallest distance list assertion macros
// clocked on clk_i, disabled while rst_ni is low
// ----------------------------------------------------------------------------
`ifndef K_SMALLEST_DISTANCE_LIST_ASSERT_SVH
`define K_SMALLEST_DISTANCE_LIST_ASSERT_SVH

// condition holds in the same cycle as the trigger
`define KSL_ASSERT_SAME(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (cond)) \
    else $error(msg);

// condition holds in the cycle after the trigger
`define KSL_ASSERT_NEXT(lbl, trig, cond, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |=> (cond)) \
    else $error(msg);

`endif

@@ rtl/kslist_pkg.sv @@
// ----------------------------------------------------------------------------
// kslist_pkg
// shared sizes, codes and controller/datapath interface types
// ----------------------------------------------------------------------------
`default_nettype none

package kslist_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int SLOT_W      = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
  localparam int OFF_W       = $clog2(MAX_ENTRIES + 1);
  localparam int DIST_W      = 32;
  localparam int IDX_W       = 12;
  localparam int ACT_W       = 5;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int S_TDATA_W   = ((DIST_W + IDX_W + 7) / 8) * 8;
  localparam int M_TDATA_W   = ((2 * DIST_W + IDX_W + 7) / 8) * 8;

  localparam logic [DIST_W-1:0] CUTOFF_RESET = DIST_W'(2000000);
  localparam logic [ACT_W-1:0]  ACTIVE_RESET = ACT_W'(13);

  typedef enum logic [1:0] {
    ACT_CLEAR  = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_READ   = 2'd2
  } action_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_CUTOFF = CFG_IDX_W'(0),
    REG_ACTIVE = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CMD_NONE   = 2'd0,
    CMD_CLEAR  = 2'd1,
    CMD_INSERT = 2'd2,
    CMD_ENTRY  = 2'd3
  } cmd_op_e;

  typedef struct packed {
    cmd_op_e           op;
    logic              load;
    logic              last;
    logic [SLOT_W-1:0] rd_ptr;
  } dp_cmd_t;

  typedef struct packed {
    logic [SLOT_W-1:0] n_last;
  } dp_status_t;

endpackage

`default_nettype wire

@@ rtl/kslist_ctrl.sv @@
// ----------------------------------------------------------------------------
// kslist_ctrl
// sequencer: accepts words, issues datapath commands, walks read-out runs
// ----------------------------------------------------------------------------
`default_nettype none

module kslist_ctrl
  import kslist_pkg::*;
(
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire action_e    in_action_i,
  output logic            in_ready_o,
  output logic            out_valid_o,
  input  wire logic       out_ready_i,
  input  wire dp_status_t status_i,
  output dp_cmd_t         cmd_o
);

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_READ = 2'b10
  } state_e;

  state_e            state_q, state_d;
  logic [SLOT_W-1:0] ptr_q, ptr_d;
  logic              out_valid_q, out_valid_d;
  logic              out_free;
  logic              accept;

  // output register is free when empty or drained this cycle
  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == ST_IDLE) && out_free;
  assign accept      = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d     = state_q;
    ptr_d       = ptr_q;
    out_valid_d = out_valid_q && !out_ready_i;
    cmd_o       = '{op: CMD_NONE, load: 1'b0, last: 1'b0, rd_ptr: ptr_q};
    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (in_action_i)
            ACT_CLEAR: begin
              cmd_o.op = CMD_CLEAR;
            end
            ACT_INSERT: begin
              cmd_o.op    = CMD_INSERT;
              cmd_o.load  = 1'b1;
              cmd_o.last  = 1'b1;
              out_valid_d = 1'b1;
            end
            ACT_READ: begin
              state_d = ST_READ;
              ptr_d   = '0;
            end
            default: begin
            end
          endcase
        end
      end
      ST_READ: begin
        if (out_free) begin
          cmd_o.op    = CMD_ENTRY;
          cmd_o.load  = 1'b1;
          cmd_o.last  = (ptr_q == status_i.n_last);
          out_valid_d = 1'b1;
          if (ptr_q == status_i.n_last) begin
            state_d = ST_IDLE;
          end else begin
            ptr_d = ptr_q + SLOT_W'(1);
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ptr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ptr_q       <= ptr_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

`default_nettype wire

@@ rtl/kslist_dp.sv @@
// ----------------------------------------------------------------------------
// kslist_dp
// config registers, row of compare-and-shift cells and output word register
// ----------------------------------------------------------------------------
`default_nettype none

module kslist_dp
  import kslist_pkg::*;
(
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic                   cfg_we_i,
  input  wire cfg_reg_e               cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data_i,
  input  wire logic [DIST_W-1:0]      in_distance_i,
  input  wire logic [IDX_W-1:0]       in_item_index_i,
  input  wire dp_cmd_t                cmd_i,
  output dp_status_t                  status_o,
  output logic [DIST_W-1:0]           worst_distance_o,
  output logic [DIST_W-1:0]           entry_distance_o,
  output logic [IDX_W-1:0]            entry_index_o,
  output logic                        entry_valid_o,
  output logic                        last_o
);

  logic [DIST_W-1:0] cutoff_q, cutoff_d;
  logic [ACT_W-1:0]  active_q, active_d;

  logic [DIST_W-1:0] dist_q  [MAX_ENTRIES];
  logic [DIST_W-1:0] dist_d  [MAX_ENTRIES];
  logic [IDX_W-1:0]  point_q [MAX_ENTRIES];
  logic [IDX_W-1:0]  point_d [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] filled_q, filled_d;
  logic [OFF_W-1:0]  offered_q, offered_d;

  logic [DIST_W-1:0] prev_dist  [MAX_ENTRIES];
  logic [IDX_W-1:0]  prev_point [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] prev_filled;

  logic [SLOT_W-1:0] n_last;
  logic [OFF_W-1:0]  n_cnt;
  logic [OFF_W-1:0]  offered_new;
  logic [SLOT_W-1:0] top_pos;
  logic [SLOT_W-1:0] ins_pos;
  logic              hit;

  logic [DIST_W-1:0] worst_q, worst_d;
  logic [DIST_W-1:0] ent_dist_q, ent_dist_d;
  logic [IDX_W-1:0]  ent_idx_q, ent_idx_d;
  logic              ent_valid_q, ent_valid_d;
  logic              last_q, last_d;

  // config writes
  always_comb begin
    cutoff_d = cutoff_q;
    active_d = active_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        REG_CUTOFF: cutoff_d = cfg_data_i[DIST_W-1:0];
        REG_ACTIVE: active_d = cfg_data_i[ACT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // list size clamped to 1..MAX_ENTRIES, kept as last position
  always_comb begin
    if (active_q == '0) begin
      n_last = '0;
    end else if (int'(active_q) >= MAX_ENTRIES) begin
      n_last = SLOT_W'(MAX_ENTRIES - 1);
    end else begin
      n_last = SLOT_W'(active_q - ACT_W'(1));
    end
  end

  assign n_cnt             = OFF_W'(n_last) + OFF_W'(1);
  assign offered_new       = (offered_q < n_cnt) ? (offered_q + OFF_W'(1)) : n_cnt;
  assign top_pos           = SLOT_W'(offered_new - OFF_W'(1));
  assign hit               = in_distance_i < dist_q[n_last];
  assign status_o.n_last   = n_last;

  // neighbor taps for the shift
  always_comb begin
    prev_dist[0]   = dist_q[0];
    prev_point[0]  = point_q[0];
    prev_filled[0] = filled_q[0];
    for (int j = 1; j < MAX_ENTRIES; j++) begin
      prev_dist[j]   = dist_q[j-1];
      prev_point[j]  = point_q[j-1];
      prev_filled[j] = filled_q[j-1];
    end
  end

  // insert position: just above the highest entry at or below the candidate
  always_comb begin
    ins_pos = '0;
    for (int m = 0; m < MAX_ENTRIES; m++) begin
      if ((SLOT_W'(m) < top_pos) && (dist_q[m] <= in_distance_i)) begin
        ins_pos = SLOT_W'(m + 1);
      end
    end
  end

  always_comb begin
    dist_d    = dist_q;
    point_d   = point_q;
    filled_d  = filled_q;
    offered_d = offered_q;
    case (cmd_i.op)
      CMD_CLEAR: begin
        for (int j = 0; j < MAX_ENTRIES; j++) begin
          dist_d[j]   = cutoff_q;
          point_d[j]  = '0;
          filled_d[j] = 1'b0;
        end
        offered_d = '0;
      end
      CMD_INSERT: begin
        offered_d = offered_new;
        if (hit) begin
          for (int j = 0; j < MAX_ENTRIES; j++) begin
            if (SLOT_W'(j) == ins_pos) begin
              dist_d[j]   = in_distance_i;
              point_d[j]  = in_item_index_i;
              filled_d[j] = 1'b1;
            end else if ((SLOT_W'(j) > ins_pos) && (SLOT_W'(j) <= top_pos)) begin
              dist_d[j]   = prev_dist[j];
              point_d[j]  = prev_point[j];
              filled_d[j] = prev_filled[j];
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // output word
  always_comb begin
    worst_d     = worst_q;
    ent_dist_d  = ent_dist_q;
    ent_idx_d   = ent_idx_q;
    ent_valid_d = ent_valid_q;
    last_d      = last_q;
    if (cmd_i.load) begin
      worst_d = dist_d[n_last];
      last_d  = cmd_i.last;
      if (cmd_i.op == CMD_ENTRY) begin
        ent_dist_d  = dist_q[cmd_i.rd_ptr];
        ent_idx_d   = point_q[cmd_i.rd_ptr];
        ent_valid_d = filled_q[cmd_i.rd_ptr];
      end else begin
        ent_dist_d  = '0;
        ent_idx_d   = '0;
        ent_valid_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff_q  <= CUTOFF_RESET;
      active_q  <= ACTIVE_RESET;
      filled_q  <= '0;
      offered_q <= '0;
      for (int j = 0; j < MAX_ENTRIES; j++) begin
        dist_q[j]  <= CUTOFF_RESET;
        point_q[j] <= '0;
      end
    end else begin
      cutoff_q  <= cutoff_d;
      active_q  <= active_d;
      filled_q  <= filled_d;
      offered_q <= offered_d;
      dist_q    <= dist_d;
      point_q   <= point_d;
    end
  end

  always_ff @(posedge clk_i) begin
    worst_q     <= worst_d;
    ent_dist_q  <= ent_dist_d;
    ent_idx_q   <= ent_idx_d;
    ent_valid_q <= ent_valid_d;
    last_q      <= last_d;
  end

  assign worst_distance_o = worst_q;
  assign entry_distance_o = ent_dist_q;
  assign entry_index_o    = ent_idx_q;
  assign entry_valid_o    = ent_valid_q;
  assign last_o           = last_q;

endmodule

`default_nettype wire

@@ rtl/k_smallest_distance_list.sv @@
// ----------------------------------------------------------------------------
// k_smallest_distance_list
// sorted list of the nearest candidates for a knn search
// ----------------------------------------------------------------------------
//  channel   direction  word contents
//  s_axis    in         tuser: action; tdata: distance, item_index
//  m_axis    out        tdata: worst, entry distance, entry index; tuser: valid
//  cfg       in         cfg_index_i selects register, cfg_data_i holds value
//
//  clear and insert complete when accepted; an insert word appears on m_axis
//  the cycle after it is accepted. a read-out first enters the read state and
//  then loads list size entry words as m_axis frees, with no new input taken.
//  the cell row compares and shifts all entries in parallel.
//  reset loads every entry with the default cutoff and marks it empty.
//  a stalled m_axis holds its word and s_axis waits until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

`include "k_smallest_distance_list_assert.svh"

module k_smallest_distance_list
  import kslist_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  // config write channel
  input  wire logic                  cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_data_i,
  // input stream
  input  wire logic                  s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire logic [S_TDATA_W-1:0]  s_axis_tdata,  // distance, item_index, zero pad
  input  wire logic [1:0]            s_axis_tuser,  // action
  // result stream
  output logic                       m_axis_tvalid,
  input  wire logic                  m_axis_tready,
  output logic [M_TDATA_W-1:0]       m_axis_tdata,  // worst_distance, entry_distance,
                                                    // entry_index, zero pad
  output logic [0:0]                 m_axis_tuser,  // entry_valid
  output logic                       m_axis_tlast
);

  dp_cmd_t           cmd;
  dp_status_t        status;
  logic [DIST_W-1:0] worst_distance;
  logic [DIST_W-1:0] entry_distance;
  logic [IDX_W-1:0]  entry_index;
  logic              entry_valid;

  assign cfg_ready_o = 1'b1;

  kslist_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_action_i (action_e'(s_axis_tuser)),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  kslist_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_valid_i && cfg_ready_o),
    .cfg_index_i      (cfg_reg_e'(cfg_index_i)),
    .cfg_data_i       (cfg_data_i),
    .in_distance_i    (s_axis_tdata[DIST_W-1:0]),
    .in_item_index_i  (s_axis_tdata[DIST_W+IDX_W-1:DIST_W]),
    .cmd_i            (cmd),
    .status_o         (status),
    .worst_distance_o (worst_distance),
    .entry_distance_o (entry_distance),
    .entry_index_o    (entry_index),
    .entry_valid_o    (entry_valid),
    .last_o           (m_axis_tlast)
  );

  assign m_axis_tdata = M_TDATA_W'({entry_index, entry_distance, worst_distance});
  assign m_axis_tuser = entry_valid;

  `KSL_ASSERT_SAME(a_no_accept_over_held_word, s_axis_tready,
    !m_axis_tvalid || m_axis_tready, "input accepted while result word is stuck")

  `KSL_ASSERT_NEXT(a_insert_gives_last_word,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_INSERT),
    m_axis_tvalid && m_axis_tlast && (m_axis_tuser == 1'b0),
    "insert did not produce a final word")

  `KSL_ASSERT_NEXT(a_readout_blocks_input,
    s_axis_tvalid && s_axis_tready && (s_axis_tuser == ACT_READ),
    !s_axis_tready, "input open during read-out")

endmodule

`default_nettype wire

@@ bench/kslist_checker.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// kslist_checker
// watches the config, input and result channels of the nearest-candidate
// list, keeps its own copy of the sorted list and compares every result word
// with the oldest predicted word
// ----------------------------------------------------------------------------
module kslist_checker
  import kslist_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  s_tvalid_i,
  input  logic                  s_tready_i,
  input  logic [S_TDATA_W-1:0]  s_tdata_i,   // distance, item_index, zero pad
  input  logic [1:0]            s_tuser_i,   // action
  input  logic                  m_tvalid_i,
  input  logic                  m_tready_i,
  input  logic [M_TDATA_W-1:0]  m_tdata_i,   // worst, entry distance, entry index
  input  logic [0:0]            m_tuser_i,   // entry_valid
  input  logic                  m_tlast_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [DIST_W-1:0] worst;
    logic [DIST_W-1:0] entry_dist;
    logic [IDX_W-1:0]  entry_idx;
    logic              entry_valid;
    logic              last;
  } list_word_t;

  logic [DIST_W-1:0] slot_dist   [MAX_ENTRIES];
  logic [IDX_W-1:0]  slot_point  [MAX_ENTRIES];
  logic              slot_filled [MAX_ENTRIES];
  int                offered;
  logic [DIST_W-1:0] cutoff;
  logic [ACT_W-1:0]  active;
  list_word_t        expected_words [$];
  int                failures;

  function automatic int list_size();
    if (active == 0) return 1;
    if (active > MAX_ENTRIES) return MAX_ENTRIES;
    return int'(active);
  endfunction

  task automatic clear_slots();
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      slot_dist[i]   = cutoff;
      slot_point[i]  = '0;
      slot_filled[i] = 1'b0;
    end
    offered = 0;
  endtask

  task automatic write_register();
    case (cfg_reg_e'(cfg_index_i))
      REG_CUTOFF: cutoff = cfg_data_i[DIST_W-1:0];
      REG_ACTIVE: active = cfg_data_i[ACT_W-1:0];
      default: ;
    endcase
  endtask

  task automatic predict_word();
    logic [DIST_W-1:0] cand_dist;
    logic [IDX_W-1:0]  idx;
    int                n;
    int                i;
    list_word_t        w;
    cand_dist = s_tdata_i[DIST_W-1:0];
    idx       = s_tdata_i[DIST_W +: IDX_W];
    n         = list_size();
    case (action_e'(s_tuser_i))
      ACT_CLEAR: clear_slots();
      ACT_INSERT: begin
        // a dropped insert still counts as offered
        offered = (offered < n) ? offered + 1 : n;
        if (cand_dist < slot_dist[n-1]) begin
          i = offered - 1;
          // equal distances stay ahead of the new entry
          while (i > 0 && cand_dist < slot_dist[i-1]) begin
            slot_dist[i]   = slot_dist[i-1];
            slot_point[i]  = slot_point[i-1];
            slot_filled[i] = slot_filled[i-1];
            i--;
          end
          slot_dist[i]   = cand_dist;
          slot_point[i]  = idx;
          slot_filled[i] = 1'b1;
        end
        w = '{worst: slot_dist[n-1], entry_dist: '0, entry_idx: '0,
              entry_valid: 1'b0, last: 1'b1};
        expected_words.insert(expected_words.size(), w);
      end
      ACT_READ: begin
        for (i = 0; i < n; i++) begin
          w.worst       = slot_dist[n-1];
          w.entry_dist  = slot_dist[i];
          w.entry_idx   = slot_point[i];
          w.entry_valid = slot_filled[i];
          w.last        = (i == n - 1);
          expected_words.insert(expected_words.size(), w);
        end
      end
      default: ;
    endcase
  endtask

  task automatic compare_field(input string name, input logic [DIST_W-1:0] want,
                               input logic [DIST_W-1:0] got);
    if (want !== got) begin
      failures++;
      $display("%0t %s: expected %0h, got %0h", $time, name, want, got);
    end
  endtask

  task automatic check_result();
    list_word_t want;
    list_word_t got;
    got.worst       = m_tdata_i[DIST_W-1:0];
    got.entry_dist  = m_tdata_i[DIST_W +: DIST_W];
    got.entry_idx   = m_tdata_i[2*DIST_W +: IDX_W];
    got.entry_valid = m_tuser_i[0];
    got.last        = m_tlast_i;
    if (expected_words.size() == 0) begin
      failures++;
      $display("%0t unexpected word: expected none, got %0h", $time, got);
    end else begin
      want = expected_words.pop_front();
      compare_field("worst_distance", want.worst, got.worst);
      compare_field("entry_distance", want.entry_dist, got.entry_dist);
      compare_field("entry_index", DIST_W'(want.entry_idx), DIST_W'(got.entry_idx));
      compare_field("entry_valid", DIST_W'(want.entry_valid), DIST_W'(got.entry_valid));
      compare_field("last", DIST_W'(want.last), DIST_W'(got.last));
    end
  endtask

  // results leave before a new word can be predicted in the same cycle
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cutoff   = CUTOFF_RESET;
      active   = ACTIVE_RESET;
      failures = 0;
      clear_slots();
      expected_words.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
    end else begin
      if (m_tvalid_i && m_tready_i) check_result();
      if (cfg_valid_i && cfg_ready_i) write_register();
      if (s_tvalid_i && s_tready_i) predict_word();
      fail_count_o <= failures;
      pending_o    <= expected_words.size();
    end
  end

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// drives the nearest-candidate list with directed and random clear, insert
// and read-out words under several list settings, with random stalls on both
// streams; the checker beside the block predicts and compares every result
// ----------------------------------------------------------------------------
module tb;
  import kslist_pkg::*;

  localparam logic [1:0] ACT_IGNORED   = 2'd3;
  localparam int         IDLE_LIMIT    = 2000;
  localparam int         SETTLE_CYCLES = 4;
  localparam int         PHASE_WORDS   = 70;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [S_TDATA_W-1:0]  s_axis_tdata  = '0;
  logic [1:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0]  m_axis_tdata;
  logic [0:0]            m_axis_tuser;
  logic                  m_axis_tlast;

  int fail_count;
  int pending;
  bit calm        = 1'b0;
  bit sender_gaps = 1'b1;

  always #5 clk_i = ~clk_i;

  k_smallest_distance_list u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  kslist_checker u_check (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_i (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .s_tuser_i   (s_axis_tuser),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .m_tuser_i   (m_axis_tuser),
    .m_tlast_i   (m_axis_tlast),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  wire accepted = (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                  (cfg_valid_i && cfg_ready_o);

  // watchdog: too long without any word moving
  initial begin
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(posedge clk_i);
      idle_cycles = accepted ? 0 : idle_cycles + 1;
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // result side back-pressure
  initial begin
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (calm) begin
        m_axis_tready <= 1'b1;
        @(posedge clk_i);
      end else if ($urandom_range(0, 3) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 7)) @(posedge clk_i);
      end else begin
        m_axis_tready <= 1'b1;
        repeat ($urandom_range(1, 30)) @(posedge clk_i);
      end
    end
  end

  // valid stays high after the handshake so back-to-back words need one assignment
  task automatic send_word(input logic [1:0] action, input logic [DIST_W-1:0] dist_val,
                           input logic [IDX_W-1:0] idx);
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= action;
    s_axis_tdata  <= S_TDATA_W'({idx, dist_val});
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    if (sender_gaps && !calm && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 7)) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    // a clear or an ignored word may still be in flight
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_config(input logic [DIST_W-1:0] cut, input logic [ACT_W-1:0] act);
    drain();
    cfg_valid_i <= 1'b1;
    cfg_index_i <= REG_CUTOFF;
    cfg_data_i  <= CFG_DATA_W'(cut);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_index_i <= REG_ACTIVE;
    cfg_data_i  <= CFG_DATA_W'(act);
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  function automatic logic [DIST_W-1:0] pick_cutoff();
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2:       return CUTOFF_RESET;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [ACT_W-1:0] pick_active();
    case ($urandom_range(0, 7))
      0:       return '0;
      1:       return ACT_W'(1);
      2:       return ACT_W'(MAX_ENTRIES);
      3:       return '1;
      default: return ACT_W'($urandom_range(0, 31));
    endcase
  endfunction

  // mix of full-range, below-cutoff, tie-heavy and near-cutoff distances
  function automatic logic [DIST_W-1:0] pick_distance(input logic [DIST_W-1:0] cut);
    case ($urandom_range(0, 3))
      0:       return $urandom;
      1:       return (cut == 0) ? '0 : $urandom_range(cut - 1, 0);
      2:       return $urandom_range(15, 0);
      default: return cut - $urandom_range(3, 0);
    endcase
  endfunction

  task automatic run_phase(input int words, input logic [DIST_W-1:0] cut,
                           input logic [ACT_W-1:0] act);
    int counted;
    int pick;
    set_config(cut, act);
    sender_gaps = ($urandom_range(0, 3) != 0);
    // sometimes keep the old list so a shrunk size meets a full list
    if ($urandom_range(0, 3) != 0) send_word(ACT_CLEAR, $urandom, IDX_W'($urandom));
    counted = 0;
    while (counted < words) begin
      pick = $urandom_range(0, 99);
      if (pick < 4) begin
        send_word(ACT_CLEAR, $urandom, IDX_W'($urandom));
        counted++;
      end else if (pick < 16) begin
        send_word(ACT_READ, $urandom, IDX_W'($urandom));
        counted++;
      end else if (pick < 20) begin
        send_word(ACT_IGNORED, $urandom, IDX_W'($urandom));
      end else begin
        send_word(ACT_INSERT, pick_distance(cut), IDX_W'($urandom));
        counted++;
      end
      if ($urandom_range(0, 49) == 0) drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: fresh list, extremes, ties, ignored action
    send_word(ACT_READ, '0, '0);
    send_word(ACT_INSERT, '0, '0);
    send_word(ACT_INSERT, '1, '1);
    send_word(ACT_INSERT, CUTOFF_RESET, IDX_W'(1));
    send_word(ACT_INSERT, CUTOFF_RESET - 1, '1);
    send_word(ACT_INSERT, DIST_W'(7), IDX_W'(10));
    send_word(ACT_INSERT, DIST_W'(7), IDX_W'(11));
    send_word(ACT_IGNORED, $urandom, IDX_W'($urandom));
    send_word(ACT_READ, '1, '1);
    send_word(ACT_CLEAR, '1, '1);
    send_word(ACT_READ, '0, '0);

    // widest list, top cutoff
    set_config('1, ACT_W'(MAX_ENTRIES));
    send_word(ACT_INSERT, '1, IDX_W'(5));
    send_word(ACT_INSERT, '1 - 1, IDX_W'('hABC));
    send_word(ACT_READ, '0, '0);

    // zero size setting (clamped to one entry) and zero cutoff drop everything
    set_config('0, '0);
    send_word(ACT_CLEAR, '0, '0);
    send_word(ACT_INSERT, '0, IDX_W'(3));
    send_word(ACT_READ, '0, '0);

    // size above the maximum
    set_config(DIST_W'(1000), '1);
    send_word(ACT_CLEAR, '0, '0);
    send_word(ACT_INSERT, DIST_W'(999), IDX_W'(1));
    send_word(ACT_INSERT, DIST_W'(1), IDX_W'(2));
    send_word(ACT_INSERT, DIST_W'(500), IDX_W'(3));
    send_word(ACT_READ, '0, '0);

    // shrink without clear: offered count above the new size
    set_config(DIST_W'(1000), ACT_W'(2));
    send_word(ACT_INSERT, DIST_W'(5), IDX_W'(4));
    send_word(ACT_READ, '0, '0);

    for (int phase = 0; phase < 5; phase++)
      run_phase(PHASE_WORDS, pick_cutoff(), pick_active());
    calm = 1'b1;
    run_phase(PHASE_WORDS, '1, ACT_W'(MAX_ENTRIES));

    drain();
    repeat (MAX_ENTRIES + 4) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/kslist_pkg.sv
rtl/kslist_ctrl.sv
rtl/kslist_dp.sv
rtl/k_smallest_distance_list.sv
bench/kslist_checker.sv
bench/tb.sv
